[design/first_fit_segment_allocator_top_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the first-fit segment allocator.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_TOP_ASSERT_SVH

// Assert that an expression holds on every clock edge out of reset.
`define FFA_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Assert that a condition implies a consequence on the next edge.
`define FFA_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

[design/ffsa_pkg.sv]
// ---------------------------------------------------------------------------
// ffsa_pkg
// Shared types and constants of the first-fit segment allocator.
// ---------------------------------------------------------------------------
`default_nettype none
package ffsa_pkg;
    localparam int MAX_SEGMENTS = 32;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int ADDR_W       = 20;
    localparam int LEN_W        = ADDR_W + 1;
    localparam int ENTRY_W      = ADDR_W + LEN_W + 1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FIT  = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  length;
        logic              used;
    } seg_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_SHIFT_UP,
        S_SPLIT_WR,
        S_HEAD_WR,
        S_FREE_NEXT,
        S_FREE_PREV,
        S_SHIFT_DN
    } state_t;
endpackage
`default_nettype wire

[design/ffsa_seg_ram.sv]
// ---------------------------------------------------------------------------
// ffsa_seg_ram
// Segment table memory: one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none
module ffsa_seg_ram
    import ffsa_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [IDX_W-1:0] waddr,
    input  wire seg_t             wdata,
    input  wire logic [IDX_W-1:0] raddr,
    output seg_t                  rdata
);
    seg_t mem [MAX_SEGMENTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[design/first_fit_segment_allocator_top.sv]
// The table (at most 32 segments) is scanned at one entry per cycle, then entries
// move at one per cycle for a split or a merge. A zero-byte allocation is answered
// from the idle state with no scan. One item at a time: no new item is taken
// until the result item has been accepted.
// Reset (rst_n low, asynchronous) and a pool write leave one free segment.
// ---------------------------------------------------------------------------
// first_fit_segment_allocator_top
// First-fit allocator over one pool, with the segment table held in a RAM.
// ---------------------------------------------------------------------------
`default_nettype none
module first_fit_segment_allocator_top
    import ffsa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [20:0] cfg_wdata,   // pool byte count
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,     // mode[0], alloc_size[21:1], address[41:22]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata      // status[1:0], address_out[21:2], pool_in_use[22]
);
`include "first_fit_segment_allocator_top_assert.svh"

    // Saturated pool size kept from the last write.
    logic [LEN_W-1:0] pool_reg;
    logic             init_pend_reg;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] used_cnt_reg, used_cnt_next;   // number of allocated segments
    logic [IDX_W-1:0] idx_reg, idx_next;     // scan / shift pointer
    logic [IDX_W-1:0] hit_reg, hit_next;     // segment being worked on
    logic             mode_reg, mode_next;
    logic [LEN_W-1:0] size_reg, size_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    seg_t             cur_reg, cur_next;     // segment at hit
    logic             next_free_reg, next_free_next;   // entry hit+1 is free
    logic [LEN_W-1:0] next_len_reg, next_len_next;
    logic [1:0]       shift_k_reg, shift_k_next;       // entries removed by a free
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_status_reg, out_status_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic             out_use_reg, out_use_next;

    logic             we;
    logic [IDX_W-1:0] waddr, raddr;
    seg_t             wdata, rdata;

    ffsa_seg_ram u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    logic [LEN_W-1:0] cfg_sat;
    always_comb
    begin
        cfg_sat = cfg_wdata;
        if (cfg_wdata == '0)
        begin
            cfg_sat = LEN_W'(1);
        end
        else if (cfg_wdata > LEN_W'(1 << ADDR_W))
        begin
            cfg_sat = LEN_W'(1 << ADDR_W);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg      <= LEN_W'(1 << ADDR_W);
            init_pend_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            pool_reg      <= cfg_sat;
            init_pend_reg <= 1'b1;
        end
        else if (state_reg == S_INIT)
        begin
            init_pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            count_reg      <= CNT_W'(1);
            used_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            used_cnt_reg   <= used_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        hit_reg        <= hit_next;
        mode_reg       <= mode_next;
        size_reg       <= size_next;
        addr_reg       <= addr_next;
        cur_reg        <= cur_next;
        next_free_reg  <= next_free_next;
        next_len_reg   <= next_len_next;
        shift_k_reg    <= shift_k_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_use_reg    <= out_use_next;
    end

    logic [IDX_W-1:0] last_idx;
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));

    logic match;
    always_comb
    begin
        if (mode_reg == MODE_ALLOC)
        begin
            match = !rdata.used && (rdata.length >= size_reg);
        end
        else
        begin
            match = rdata.used && (rdata.start == addr_reg);
        end
    end

    // Merge plan of a free, valid while rdata holds entry hit-1.
    logic             prev_free;
    logic [LEN_W-1:0] merged_len;
    logic [1:0]       shift_k;
    logic [CNT_W-1:0] shift_src;
    assign prev_free  = (hit_reg != '0) && !rdata.used;
    assign merged_len = cur_reg.length + (next_free_reg ? next_len_reg : LEN_W'(0));
    assign shift_k    = {1'b0, prev_free} + {1'b0, next_free_reg};
    assign shift_src  = CNT_W'(hit_reg) + CNT_W'(1) + CNT_W'(next_free_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        used_cnt_next   = used_cnt_reg;
        idx_next        = idx_reg;
        hit_next        = hit_reg;
        mode_next       = mode_reg;
        size_next       = size_reg;
        addr_next       = addr_reg;
        cur_next        = cur_reg;
        next_free_next  = next_free_reg;
        next_len_next   = next_len_reg;
        shift_k_next    = shift_k_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_use_next    = out_use_reg;
        we              = 1'b0;
        waddr           = idx_reg;
        wdata           = cur_reg;
        raddr           = idx_reg;
        s_tready        = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                we            = 1'b1;
                waddr         = '0;
                wdata.start   = '0;
                wdata.length  = pool_reg;
                wdata.used    = 1'b0;
                count_next    = CNT_W'(1);
                used_cnt_next = '0;
                state_next    = S_IDLE;
            end
            S_IDLE:
            begin
                s_tready = !out_valid_reg && !init_pend_reg;
                if (init_pend_reg)
                begin
                    state_next = S_INIT;
                end
                else if (s_tvalid && s_tready)
                begin
                    mode_next = s_tdata[0];
                    size_next = s_tdata[21:1];
                    addr_next = s_tdata[41:22];
                    idx_next  = '0;
                    raddr     = '0;
                    if (s_tdata[0] == MODE_ALLOC && s_tdata[21:1] == '0)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_NO_FIT;
                        out_addr_next   = '0;
                        out_use_next    = (used_cnt_reg != '0);
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // Read issued for idx_reg last cycle; data valid now.
                if (match)
                begin
                    hit_next = idx_reg;
                    cur_next = rdata;
                    if (mode_reg == MODE_ALLOC)
                    begin
                        if (rdata.length > size_reg)
                        begin
                            if (count_reg >= CNT_W'(MAX_SEGMENTS))
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = ST_FULL;
                                out_addr_next   = '0;
                                out_use_next    = (used_cnt_reg != '0);
                                state_next      = S_IDLE;
                            end
                            else if (idx_reg == last_idx)
                            begin
                                state_next = S_SPLIT_WR;
                            end
                            else
                            begin
                                // Move entries hit+1 .. count-1 up by one, top first.
                                idx_next   = last_idx;
                                raddr      = last_idx;
                                state_next = S_SHIFT_UP;
                            end
                        end
                        else
                        begin
                            we              = 1'b1;
                            waddr           = idx_reg;
                            wdata           = rdata;
                            wdata.used      = 1'b1;
                            used_cnt_next   = used_cnt_reg + CNT_W'(1);
                            out_valid_next  = 1'b1;
                            out_status_next = ST_OK;
                            out_addr_next   = rdata.start;
                            out_use_next    = 1'b1;
                            state_next      = S_IDLE;
                        end
                    end
                    else if (idx_reg != last_idx)
                    begin
                        raddr      = idx_reg + IDX_W'(1);
                        state_next = S_FREE_NEXT;
                    end
                    else
                    begin
                        // No entry above the last one, so nothing to merge there.
                        next_free_next = 1'b0;
                        next_len_next  = '0;
                        raddr          = idx_reg - IDX_W'(1);
                        state_next     = S_FREE_PREV;
                    end
                end
                else if (idx_reg == last_idx)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = (mode_reg == MODE_ALLOC) ? ST_NO_FIT : ST_BAD_FREE;
                    out_addr_next   = '0;
                    out_use_next    = (used_cnt_reg != '0);
                    state_next      = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                    raddr    = idx_reg + IDX_W'(1);
                end
            end
            S_SHIFT_UP:
            begin
                // rdata holds entry idx; reads run below the writes.
                we    = 1'b1;
                waddr = idx_reg + IDX_W'(1);
                wdata = rdata;
                if (idx_reg == hit_reg + IDX_W'(1))
                begin
                    state_next = S_SPLIT_WR;
                end
                else
                begin
                    idx_next = idx_reg - IDX_W'(1);
                    raddr    = idx_reg - IDX_W'(1);
                end
            end
            S_SPLIT_WR:
            begin
                // The remainder becomes a free segment right after the hit.
                we           = 1'b1;
                waddr        = hit_reg + IDX_W'(1);
                wdata.start  = cur_reg.start + size_reg[ADDR_W-1:0];
                wdata.length = cur_reg.length - size_reg;
                wdata.used   = 1'b0;
                count_next   = count_reg + CNT_W'(1);
                state_next   = S_HEAD_WR;
            end
            S_HEAD_WR:
            begin
                we              = 1'b1;
                waddr           = hit_reg;
                wdata           = cur_reg;
                wdata.length    = size_reg;
                wdata.used      = 1'b1;
                used_cnt_next   = used_cnt_reg + CNT_W'(1);
                out_valid_next  = 1'b1;
                out_status_next = ST_OK;
                out_addr_next   = cur_reg.start;
                out_use_next    = 1'b1;
                state_next      = S_IDLE;
            end
            S_FREE_NEXT:
            begin
                // rdata holds entry hit+1; fetch entry hit-1 next.
                next_free_next = !rdata.used;
                next_len_next  = rdata.length;
                raddr          = hit_reg - IDX_W'(1);
                state_next     = S_FREE_PREV;
            end
            S_FREE_PREV:
            begin
                // Write the merged segment, then close the gap left by the
                // one or two entries it swallowed.
                we = 1'b1;
                if (prev_free)
                begin
                    waddr        = hit_reg - IDX_W'(1);
                    wdata        = rdata;
                    wdata.length = rdata.length + merged_len;
                end
                else
                begin
                    waddr        = hit_reg;
                    wdata        = cur_reg;
                    wdata.length = merged_len;
                    wdata.used   = 1'b0;
                end
                shift_k_next = shift_k;
                if (shift_k != 2'd0 && shift_src < count_reg)
                begin
                    idx_next   = IDX_W'(shift_src);
                    raddr      = IDX_W'(shift_src);
                    state_next = S_SHIFT_DN;
                end
                else
                begin
                    count_next      = count_reg - CNT_W'(shift_k);
                    used_cnt_next   = used_cnt_reg - CNT_W'(1);
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_addr_next   = '0;
                    out_use_next    = (used_cnt_reg != CNT_W'(1));
                    state_next      = S_IDLE;
                end
            end
            S_SHIFT_DN:
            begin
                // rdata holds entry idx; it moves down by the removed count.
                we    = 1'b1;
                waddr = idx_reg - IDX_W'(shift_k_reg);
                wdata = rdata;
                if (idx_reg == last_idx)
                begin
                    count_next      = count_reg - CNT_W'(shift_k_reg);
                    used_cnt_next   = used_cnt_reg - CNT_W'(1);
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_addr_next   = '0;
                    out_use_next    = (used_cnt_reg != CNT_W'(1));
                    state_next      = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                    raddr    = idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_use_reg, out_addr_reg, out_status_reg};

    `FFA_ASSERT_ALWAYS(a_count_range, (count_reg != '0) && (count_reg <= CNT_W'(MAX_SEGMENTS)),
                       "segment count out of range")
    `FFA_ASSERT_ALWAYS(a_used_range, (used_cnt_reg <= count_reg), "used count above segment count")
    `FFA_ASSERT_NEXT(a_out_hold, (m_tvalid && !m_tready), (m_tvalid && $stable(m_tdata)),
                     "result item changed while stalled")
    `FFA_ASSERT_ALWAYS(a_no_accept_busy, !(s_tready && m_tvalid), "accepted while result pending")
endmodule
`default_nettype wire

[tb/ffsa_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ffsa_checker
// Watches the request, result and pool size ports of the allocator, keeps
// its own segment table, and compares every result with the expected one.
// ---------------------------------------------------------------------------
module ffsa_checker
    import ffsa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [20:0] cfg_wdata,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,
    output int               errors,
    output int               pending
);
    typedef struct packed {
        logic        in_use;
        logic [19:0] addr;
        logic [1:0]  status;
    } answer_t;

    logic [20:0] pool;
    logic [19:0] seg_start [MAX_SEGMENTS];
    logic [20:0] seg_len [MAX_SEGMENTS];
    logic        seg_used [MAX_SEGMENTS];
    int          seg_n;
    answer_t     answers [$];

    assign pending = answers.size();

    function automatic void table_reset();
        for (int k = 0; k < MAX_SEGMENTS; k++)
        begin
            seg_start[k] = '0;
            seg_len[k] = '0;
            seg_used[k] = 1'b0;
        end
        seg_len[0] = pool;
        seg_n = 1;
    endfunction

    function automatic void drop_entry(int k);
        for (int j = k; j + 1 < seg_n; j++)
        begin
            seg_start[j] = seg_start[j + 1];
            seg_len[j] = seg_len[j + 1];
            seg_used[j] = seg_used[j + 1];
        end
        seg_n--;
        seg_start[seg_n] = '0;
        seg_len[seg_n] = '0;
        seg_used[seg_n] = 1'b0;
    endfunction

    function automatic answer_t allocate_or_free(logic [47:0] req);
        answer_t a;
        logic        mode;
        logic [20:0] size;
        logic [19:0] where;
        int          i;
        mode = req[0];
        size = req[21:1];
        where = req[41:22];
        a = '0;
        if (mode == MODE_ALLOC)
        begin
            a.status = ST_NO_FIT;
            if (size != 0)
            begin
                for (i = 0; i < seg_n; i++)
                    if (!seg_used[i] && seg_len[i] >= size)
                        break;
                if (i < seg_n)
                begin
                    if (seg_len[i] > size && seg_n >= MAX_SEGMENTS)
                        a.status = ST_FULL;
                    else
                    begin
                        if (seg_len[i] > size)
                        begin
                            for (int j = seg_n; j > i + 1; j--)
                            begin
                                seg_start[j] = seg_start[j - 1];
                                seg_len[j] = seg_len[j - 1];
                                seg_used[j] = seg_used[j - 1];
                            end
                            seg_start[i + 1] = seg_start[i] + size[19:0];
                            seg_len[i + 1] = seg_len[i] - size;
                            seg_used[i + 1] = 1'b0;
                            seg_len[i] = size;
                            seg_n++;
                        end
                        seg_used[i] = 1'b1;
                        a.status = ST_OK;
                        a.addr = seg_start[i];
                    end
                end
            end
        end
        else
        begin
            a.status = ST_BAD_FREE;
            for (i = 0; i < seg_n; i++)
                if (seg_used[i] && seg_start[i] == where)
                    break;
            if (i < seg_n)
            begin
                a.status = ST_OK;
                seg_used[i] = 1'b0;
                // Coalesce with the following free segment, then the preceding one.
                if (i + 1 < seg_n && !seg_used[i + 1])
                begin
                    seg_len[i] += seg_len[i + 1];
                    drop_entry(i + 1);
                end
                if (i > 0 && !seg_used[i - 1])
                begin
                    seg_len[i - 1] += seg_len[i];
                    drop_entry(i);
                end
            end
        end
        for (int k = 0; k < seg_n; k++)
            if (seg_used[k])
                a.in_use = 1'b1;
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        answer_t got;
        logic [20:0] v;
        if (!rst_n)
        begin
            pool = 21'h100000;
            table_reset();
            answers.delete();
            errors <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                v = cfg_wdata;
                if (v == 0)
                    v = 1;
                if (v > 21'h100000)
                    v = 21'h100000;
                pool = v;
                table_reset();
            end
            if (s_tvalid && s_tready)
                answers.push_back(allocate_or_free(s_tdata));
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[22:0];
                if (answers.size() == 0)
                begin
                    $error("unexpected result item %h", m_tdata);
                    errors <= errors + 1;
                end
                else
                begin
                    want = answers.pop_front();
                    if (got.status !== want.status)
                        $error("status: expected %0d, got %0d", want.status, got.status);
                    if (got.addr !== want.addr)
                        $error("address_out: expected %h, got %h", want.addr, got.addr);
                    if (got.in_use !== want.in_use)
                        $error("pool_in_use: expected %0d, got %0d",
                               want.in_use, got.in_use);
                    if (got !== want)
                        errors <= errors + 1;
                end
            end
        end
    end
endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Drives allocate and free items at the allocator with random gaps and
// stalls, across several pool sizes, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module tb_top
    import ffsa_pkg::*;
();

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [20:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    int          errors;
    int          pending;
    int          quiet;
    logic [19:0] live [$];

    first_fit_segment_allocator_top uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    ffsa_checker chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The result side stalls for a random count before each item, and now and
    // then takes an item with no stall at all.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // Watchdog: a long stretch with no accepted item on either side means the
    // block has hung.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > 5000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Send one item after a random gap and wait for it to be taken. The
    // returned offset of a successful allocation is not known here, so the
    // list of live blocks is kept from the result side instead. Valid stays
    // high after the handshake when the next item follows with no gap.
    task automatic send(input logic mode, input logic [20:0] size,
                        input logic [19:0] where);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, where, size, mode};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Offsets of blocks granted by the block, taken from ok allocations.
    logic pend_mode [$];
    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            pend_mode.push_back(s_tdata[0]);
        if (m_tvalid && m_tready && pend_mode.size() != 0)
        begin
            if (pend_mode.pop_front() == MODE_ALLOC && m_tdata[1:0] == ST_OK)
                live.push_back(m_tdata[21:2]);
        end
    end

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // Let the last comparison settle.
        repeat (2) @(posedge clk);
    endtask

    task automatic set_pool(input logic [20:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        live.delete();
    endtask

    // Mostly allocations of sizes scaled to the pool, and frees of live
    // blocks; the rest are bad frees and odd sizes.
    task automatic random_items(input int n, input int pool);
        int pick;
        int k;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send(MODE_ALLOC, 21'($urandom_range(1, (pool / 16) + 1)), 20'($urandom));
            else if (pick < 85 && live.size() != 0)
            begin
                k = $urandom_range(0, live.size() - 1);
                send(MODE_FREE, 21'($urandom), live[k]);
                live.delete(k);
            end
            else if (pick < 92)
                send(MODE_ALLOC, 21'($urandom), 20'($urandom));
            else
                send(MODE_FREE, 21'($urandom), 20'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        quiet = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero size, oversize, exact fit of the whole pool, bad frees
        // on a free segment, an interior address and the pool's last byte, then merges.
        send(MODE_ALLOC, 21'd0, 20'd0);
        send(MODE_ALLOC, 21'h1FFFFF, 20'hFFFFF);
        send(MODE_FREE, 21'd0, 20'd0);
        send(MODE_ALLOC, 21'h100000, 20'd0);
        send(MODE_FREE, 21'd0, 20'd5);
        send(MODE_FREE, 21'd0, 20'd0);
        send(MODE_ALLOC, 21'd100, 20'd0);
        send(MODE_ALLOC, 21'd200, 20'd0);
        send(MODE_ALLOC, 21'd300, 20'd0);
        send(MODE_FREE, 21'd0, 20'd50);
        send(MODE_FREE, 21'd0, 20'd100);
        send(MODE_FREE, 21'd0, 20'd0);
        send(MODE_FREE, 21'd0, 20'd300);
        send(MODE_FREE, 21'd0, 20'hFFFFF);

        // Full table: 31 single bytes leave a split that cannot fit.
        set_pool(21'd0);
        send(MODE_ALLOC, 21'd1, 20'd0);
        send(MODE_ALLOC, 21'd1, 20'd0);
        send(MODE_FREE, 21'd0, 20'd0);
        set_pool(21'h1FFFFF);
        for (int i = 0; i < 32; i++)
            send(MODE_ALLOC, 21'd1, 20'd0);
        send(MODE_FREE, 21'd0, 20'd3);
        send(MODE_ALLOC, 21'd1, 20'd0);

        set_pool(21'd64);
        random_items(500, 64);
        set_pool(21'd1000);
        random_items(500, 1000);
        set_pool(21'h100000);
        random_items(500, 1048576);
        set_pool(21'd2);
        random_items(120, 2);
        set_pool(21'd4096);
        random_items(250, 4096);

        drain();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
